/* sv/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types, constants and the delta fold for the multi-turn tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

  localparam int MotorCountDef = 4;
  localparam int MotorW        = 2;
  localparam int PosW          = 32;
  localparam int TorqueW       = 16;
  localparam int CountW        = 32;

  localparam logic [PosW-1:0] WrapHalf = PosW'(8192);
  localparam logic [PosW-1:0] WrapFull = PosW'(16384);
  localparam logic [PosW-1:0] NegHalf  = PosW'(0) - WrapHalf;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_HOME   = 1'b1
  } req_e;

  typedef struct packed {
    req_e                       req_type;
    logic [MotorW-1:0]          motor;
    logic                       frame_ok;
    logic signed [PosW-1:0]     raw_position;
    logic signed [TorqueW-1:0]  raw_torque;
  } item_t;

  typedef struct packed {
    logic [MotorW-1:0]          motor_out;
    logic                       updated;
    logic signed [PosW-1:0]     position_out;
    logic signed [TorqueW-1:0]  torque_out;
    logic [CountW-1:0]          good_frames;
    logic [CountW-1:0]          bad_frames;
  } result_t;

  // fold a raw difference into the half-turn window
  function automatic logic [PosW-1:0] fold_delta(input logic [PosW-1:0] d);
    logic [PosW-1:0] r;
    r = d;
    if (!d[PosW-1] && (d > WrapHalf)) begin
      r = d - WrapFull;
    end else if (d[PosW-1] && (d < NegHalf)) begin
      r = d + WrapFull;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/mpt_in_if.sv */
// ----------------------------------------------------------------------------
// mpt_in_if
// Request channel: status samples and home-capture beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpt_in_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [1:0]          motor;
  logic                frame_ok;
  logic signed [31:0]  raw_position;
  logic signed [15:0]  raw_torque;

  modport source (
    output valid, req_type, motor, frame_ok, raw_position, raw_torque,
    input  ready
  );
  modport sink (
    input  valid, req_type, motor, frame_ok, raw_position, raw_torque,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mpt_out_if.sv */
// ----------------------------------------------------------------------------
// mpt_out_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpt_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          motor_out;
  logic                updated;
  logic signed [31:0]  position_out;
  logic signed [15:0]  torque_out;
  logic [31:0]         good_frames;
  logic [31:0]         bad_frames;

  modport source (
    output valid, motor_out, updated, position_out, torque_out, good_frames,
           bad_frames,
    input  ready
  );
  modport sink (
    input  valid, motor_out, updated, position_out, torque_out, good_frames,
           bad_frames,
    output ready
  );
endinterface

`default_nettype wire

/* sv/multiturn_position_tracker.sv */
// a request beat passes the input register, then the result register, to result valid
// one request per cycle while results drain, set by the single-pass per-motor update
// while a result waits the input register takes one more beat, then ready drops
// reset: asynchronous active low; clears all per-motor state and both frame counters
// ----------------------------------------------------------------------------
// multiturn_position_tracker
// Unwraps encoder positions of several motors into multi-turn counts with
// home-offset capture and good/bad frame counting.
// ----------------------------------------------------------------------------
`default_nettype none

module multiturn_position_tracker
  import mpt_pkg::*;
#(
  parameter int MOTOR_COUNT = MotorCountDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mpt_in_if.sink    in_i,
  mpt_out_if.source out_o
);

  item_t   item_q, item_d;
  logic    in_vld_q;
  result_t res_q, res_d;
  logic    out_vld_q;
  logic    advance, commit;

  assign advance    = !out_vld_q || out_o.ready;
  assign commit     = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_comb begin
    item_d.req_type     = req_e'(in_i.req_type);
    item_d.motor        = in_i.motor;
    item_d.frame_ok     = in_i.frame_ok;
    item_d.raw_position = in_i.raw_position;
    item_d.raw_torque   = in_i.raw_torque;
  end

  mpt_core #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (commit),
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.motor_out    = res_q.motor_out;
  assign out_o.updated      = res_q.updated;
  assign out_o.position_out = res_q.position_out;
  assign out_o.torque_out   = res_q.torque_out;
  assign out_o.good_frames  = res_q.good_frames;
  assign out_o.bad_frames   = res_q.bad_frames;

endmodule

`default_nettype wire

/* sv/mpt_core.sv */
// ----------------------------------------------------------------------------
// mpt_core
// Per-motor tracking state, frame counters and the single-pass update.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_core
  import mpt_pkg::*;
#(
  parameter int MOTOR_COUNT = MotorCountDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [PosW-1:0]    last_q  [MOTOR_COUNT];
  logic [PosW-1:0]    acc_q   [MOTOR_COUNT];
  logic [PosW-1:0]    rel_q   [MOTOR_COUNT];
  logic [PosW-1:0]    phold_q [MOTOR_COUNT];
  logic [TorqueW-1:0] thold_q [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] synced_q, homed_q;
  logic [CountW-1:0]  good_q, good_d, bad_q, bad_d;

  logic [MOTOR_COUNT-1:0] sel;
  logic               in_range;
  logic [PosW-1:0]    last_s, acc_s, rel_s, ph_s, pos, fold, acc_f, rel_f;
  logic [TorqueW-1:0] tq_s;
  logic               syn_s, hom_s;
  logic               is_home, good, bad, seed, track;
  logic [PosW-1:0]    last_d, acc_d, rel_d, ph_d;
  logic [TorqueW-1:0] tq_d;

  // motor select and read of the addressed slot
  always_comb begin
    sel    = '0;
    last_s = '0;
    acc_s  = '0;
    rel_s  = '0;
    ph_s   = '0;
    tq_s   = '0;
    syn_s  = 1'b0;
    hom_s  = 1'b0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      sel[k] = (PosW'(item_i.motor) == PosW'(k));
      if (sel[k]) begin
        last_s = last_q[k];
        acc_s  = acc_q[k];
        rel_s  = rel_q[k];
        ph_s   = phold_q[k];
        tq_s   = thold_q[k];
        syn_s  = synced_q[k];
        hom_s  = homed_q[k];
      end
    end
  end

  assign in_range = |sel;
  assign pos      = item_i.raw_position;
  assign is_home  = (item_i.req_type == REQ_HOME);
  assign good     = in_range && !is_home && item_i.frame_ok;
  assign bad      = in_range && !is_home && !item_i.frame_ok;
  assign seed     = good && !syn_s;
  assign track    = good && syn_s;

  assign fold  = fold_delta(pos - last_s);
  assign acc_f = acc_s + fold;
  // rel tracks accumulated minus home offset
  assign rel_f = rel_s + fold;

  always_comb begin
    last_d = good ? pos : last_s;
    acc_d  = seed ? pos : (track ? acc_f : acc_s);
    rel_d  = rel_s;
    if (seed) begin
      rel_d = pos;
    end else if (track) begin
      rel_d = rel_f;
    end else if (is_home) begin
      rel_d = '0;
    end
    ph_d   = track ? (hom_s ? rel_f : pos) : ph_s;
    tq_d   = track ? item_i.raw_torque : tq_s;
    good_d = good_q + CountW'(good);
    bad_d  = bad_q + CountW'(bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q <= '0;
      homed_q  <= '0;
      good_q   <= '0;
      bad_q    <= '0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        last_q[k]  <= '0;
        acc_q[k]   <= '0;
        rel_q[k]   <= '0;
        phold_q[k] <= '0;
        thold_q[k] <= '0;
      end
    end else if (en_i) begin
      good_q <= good_d;
      bad_q  <= bad_d;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        if (sel[k]) begin
          last_q[k]   <= last_d;
          acc_q[k]    <= acc_d;
          rel_q[k]    <= rel_d;
          phold_q[k]  <= ph_d;
          thold_q[k]  <= tq_d;
          synced_q[k] <= syn_s | good;
          homed_q[k]  <= hom_s | is_home;
        end
      end
    end
  end

  always_comb begin
    result_o.motor_out    = item_i.motor;
    result_o.updated      = track;
    result_o.position_out = in_range ? ph_d : '0;
    result_o.torque_out   = in_range ? tq_d : '0;
    result_o.good_frames  = good_d;
    result_o.bad_frames   = bad_d;
  end

endmodule

`default_nettype wire
